// ===== hw/rtl/orss_pkg.sv =====
`default_nettype none
package orss_pkg;

  localparam int DIVIDEND_W = 23;
  localparam int DIVISOR_W  = 12;

  localparam logic [1:0] CMD_SETUP   = 2'd0;
  localparam logic [1:0] CMD_DISPLAY = 2'd1;
  localparam logic [1:0] CMD_RESTORE = 2'd2;
  localparam logic [1:0] CMD_HIDE    = 2'd3;

  localparam logic [0:0] CFG_SCREEN_MODE = 1'b0;
  localparam logic [0:0] CFG_SCALER_BASE = 1'b1;

  localparam logic [1:0] MODE_555     = 2'd0;
  localparam logic [1:0] MODE_565     = 2'd1;
  localparam logic [1:0] MODE_PALETTE = 2'd2;
  localparam logic [1:0] MODE_TRUE    = 2'd3;

  localparam logic [3:0] REG_BUS_EN    = 4'd0;
  localparam logic [3:0] REG_SCALE_CTL = 4'd1;
  localparam logic [3:0] REG_INCREMENT = 4'd2;
  localparam logic [3:0] REG_FORMAT    = 4'd3;
  localparam logic [3:0] REG_PITCH     = 4'd4;
  localparam logic [3:0] REG_SIZE      = 4'd5;
  localparam logic [3:0] REG_CAPTURE   = 4'd6;
  localparam logic [3:0] REG_START     = 4'd7;
  localparam logic [3:0] REG_END       = 4'd8;
  localparam logic [3:0] REG_OFFSET    = 4'd9;
  localparam logic [3:0] REG_KEY_MASK  = 4'd10;
  localparam logic [3:0] REG_KEY_COLOR = 4'd11;
  localparam logic [3:0] REG_KEY_CTL   = 4'd12;

  localparam logic [31:0] ENABLE_CLEAR = 32'h3fff_ffff;
  localparam logic [31:0] FORMAT_WORD  = 32'h000b_0000;
  localparam logic [31:0] CAPTURE_WORD = 32'h0004_0000;
  localparam logic [31:0] KEY_CTL_WORD = 32'h0000_0050;
  localparam logic [15:0] INC_SAT      = 16'hffff;

  typedef struct packed {
    logic [1:0]  command;
    logic        source_is_y422;
    logic [9:0]  source_width;
    logic [10:0] source_height;
    logic [15:0] source_pitch;
    logic [11:0] dest_left;
    logic [11:0] dest_top;
    logic [11:0] dest_right;
    logic [11:0] dest_bottom;
    logic [23:0] key_color_rgb;
    logic [31:0] buffer_offset;
  } orss_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [3:0]  register_select;
    logic [31:0] register_data;
    logic        status;
    logic        last_result;
  } orss_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic       div_sel_v;
    logic       store_h;
    logic       store_v;
    logic       commit;
    logic       disp_start;
    logic       disp_full;
    logic       load_out;
    logic       out_ack;
    logic [3:0] out_sel;
    logic       out_last;
  } orss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       y422;
    logic       due;
    logic       div_done;
    logic       out_free;
  } orss_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/orss_stream_if.sv =====
`default_nettype none
interface orss_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/overlay_register_setup_sequencer_core.sv =====
// Overlay register setup sequencer.
// Commands arrive on the item channel and the register writes they cause
// leave on the result channel; both use valid/ready, and a transfer
// happens on a rising clock edge with both high. Configuration registers
// (screen color mode, scaler control base) are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while no command
// is in flight, as the block itself does not enforce it.
// One command is worked on at a time. A display, restore or hide is
// captured and decoded, then gives one result per cycle while the receiver
// takes them, two for the two-write forms and a full reprogram otherwise;
// the next item can transfer once the last result is loaded. A setup runs
// two 23-step divisions on one shared bit-serial divider before its single
// acknowledge; a rejected setup skips both divisions and is acknowledged.
// The next item is taken while the final result still waits in the output
// register. When the receiver stalls, the output register holds its word
// and the sequence pauses until it is taken.
// Reset (synchronous, active high) clears all shadows and the current
// offset, empties the output register, marks a full reprogram as due, and
// restores the configuration defaults.
`default_nettype none
module overlay_register_setup_sequencer_core
  import orss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  orss_stream_if.sink      item,
  orss_stream_if.source    result,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [29:0] cfg_data
);

  orss_cmd_t  ctl;
  orss_stat_t stat;

  orss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  orss_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .item_payload   (item.payload),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/orss_divider.sv =====
`default_nettype none
module orss_divider
  import orss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   rem_shift;
  logic                 fits;

  // Restoring division, one quotient bit per cycle, msb first.
  assign rem_shift = {rem, quotient[DIVIDEND_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(rem_shift - {1'b0, dvs});
      end else begin
        rem <= rem_shift[DIVISOR_W-1:0];
      end
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/orss_datapath.sv =====
`default_nettype none
module orss_datapath
  import orss_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire orss_cmd_t    ctl,
  output orss_stat_t        stat,
  input  wire orss_item_t   item_payload,
  output logic              result_valid,
  input  wire logic         result_ready,
  output orss_result_t      result_payload,
  input  wire logic         cfg_write,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [29:0]  cfg_data
);

  logic [1:0]  screen_color_mode;
  logic [29:0] scaler_control_base;

  orss_item_t  cur;

  logic [31:0] scale_control_shadow;
  logic [31:0] scale_increment_shadow;
  logic [15:0] pitch_shadow;
  logic [31:0] size_shadow;
  logic [31:0] start_corner_shadow;
  logic [31:0] end_corner_shadow;
  logic [23:0] key_color_shadow;
  logic [23:0] key_mask_shadow;
  logic [31:0] current_offset;
  logic        reprogram_due;

  logic [15:0] inc_h;
  logic [15:0] inc_v;

  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic [15:0]           quot_sat;
  logic                  zero_span_h;
  logic                  zero_span_v;

  logic [7:0]  key_r;
  logic [7:0]  key_g;
  logic [7:0]  key_b;
  logic [23:0] key_color_next;
  logic [23:0] key_mask_next;
  logic [31:0] write_data;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_color_mode   <= MODE_TRUE;
      scaler_control_base <= 30'd12;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCREEN_MODE: screen_color_mode   <= cfg_data[1:0];
        CFG_SCALER_BASE: scaler_control_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur <= item_payload;
    end
  end

  // A span counts as zero when the far edge is not beyond the near one.
  assign zero_span_h = cur.dest_right <= cur.dest_left;
  assign zero_span_v = cur.dest_bottom <= cur.dest_top;

  always_comb begin
    if (ctl.div_sel_v) begin
      div_dividend = {cur.source_height, 12'd0};
      div_divisor  = cur.dest_bottom - cur.dest_top;
    end else begin
      div_dividend = {1'b0, cur.source_width, 12'd0};
      div_divisor  = cur.dest_right - cur.dest_left;
    end
  end

  orss_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign quot_sat = (|div_quotient[DIVIDEND_W-1:16]) ? INC_SAT : div_quotient[15:0];

  always_ff @(posedge clk) begin
    if (ctl.store_h) begin
      inc_h <= zero_span_h ? INC_SAT : quot_sat;
    end
    if (ctl.store_v) begin
      inc_v <= zero_span_v ? INC_SAT : quot_sat;
    end
  end

  assign key_r = cur.key_color_rgb[23:16];
  assign key_g = cur.key_color_rgb[15:8];
  assign key_b = cur.key_color_rgb[7:0];

  always_comb begin
    unique case (screen_color_mode)
      MODE_555: begin
        key_color_next = {9'd0, key_r[7:3], key_g[7:3], key_b[7:3]};
        key_mask_next  = 24'h00_7fff;
      end
      MODE_565: begin
        key_color_next = {8'd0, key_r[7:3], key_g[7:2], key_b[7:3]};
        key_mask_next  = 24'h00_ffff;
      end
      MODE_PALETTE: begin
        key_color_next = cur.key_color_rgb;
        key_mask_next  = 24'h00_00ff;
      end
      default: begin
        key_color_next = cur.key_color_rgb;
        key_mask_next  = 24'hff_ffff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_control_shadow   <= '0;
      scale_increment_shadow <= '0;
      pitch_shadow           <= '0;
      size_shadow            <= '0;
      start_corner_shadow    <= '0;
      end_corner_shadow      <= '0;
      key_color_shadow       <= '0;
      key_mask_shadow        <= '0;
      current_offset         <= '0;
      reprogram_due          <= 1'b1;
    end else begin
      if (ctl.commit) begin
        scale_control_shadow   <= {2'b11, scaler_control_base};
        scale_increment_shadow <= {inc_h, inc_v};
        pitch_shadow           <= {1'b0, cur.source_pitch[15:1]};
        size_shadow            <= {6'd0, cur.source_width, 5'd0, cur.source_height};
        start_corner_shadow    <= {4'd0, cur.dest_left, 4'd0, cur.dest_top};
        end_corner_shadow      <= {4'd0, cur.dest_right, 4'd0, cur.dest_bottom};
        key_color_shadow       <= key_color_next;
        key_mask_shadow        <= key_mask_next;
        reprogram_due          <= 1'b1;
      end
      if (ctl.disp_start) begin
        // Restore keeps the offset of the last displayed buffer.
        if (cur.command == CMD_DISPLAY) begin
          current_offset <= cur.buffer_offset;
        end
        if (ctl.disp_full) begin
          reprogram_due <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    unique case (ctl.out_sel)
      REG_BUS_EN:    write_data = '0;
      REG_SCALE_CTL: write_data = (cur.command == CMD_HIDE) ?
                                  (scale_control_shadow & ENABLE_CLEAR) :
                                  scale_control_shadow;
      REG_INCREMENT: write_data = scale_increment_shadow;
      REG_FORMAT:    write_data = FORMAT_WORD;
      REG_PITCH:     write_data = {16'd0, pitch_shadow};
      REG_SIZE:      write_data = size_shadow;
      REG_CAPTURE:   write_data = CAPTURE_WORD;
      REG_START:     write_data = start_corner_shadow;
      REG_END:       write_data = end_corner_shadow;
      REG_OFFSET:    write_data = current_offset;
      REG_KEY_MASK:  write_data = {8'd0, key_mask_shadow};
      REG_KEY_COLOR: write_data = {8'd0, key_color_shadow};
      REG_KEY_CTL:   write_data = KEY_CTL_WORD;
      default:       write_data = '0;
    endcase
  end

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      if (ctl.out_ack) begin
        result_payload.write_valid     <= 1'b0;
        result_payload.register_select <= REG_BUS_EN;
        result_payload.register_data   <= '0;
        result_payload.status          <= !cur.source_is_y422;
        result_payload.last_result     <= 1'b1;
      end else begin
        result_payload.write_valid     <= 1'b1;
        result_payload.register_select <= ctl.out_sel;
        result_payload.register_data   <= write_data;
        result_payload.status          <= 1'b0;
        result_payload.last_result     <= ctl.out_last;
      end
    end
  end

  assign stat.command  = cur.command;
  assign stat.y422     = cur.source_is_y422;
  assign stat.due      = reprogram_due;
  assign stat.div_done = div_done;
  assign stat.out_free = out_free;

endmodule
`default_nettype wire

// ===== hw/rtl/orss_ctrl.sv =====
`default_nettype none
module orss_ctrl
  import orss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire orss_stat_t  stat,
  output orss_cmd_t        ctl
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_DIV_H  = 7'b0000100,
    S_DIV_V  = 7'b0001000,
    S_COMMIT = 7'b0010000,
    S_ACK    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [3:0] seq;
  logic [3:0] seq_next;
  logic       full;
  logic       full_next;
  logic       start_full;
  logic [3:0] sel_after;
  logic       sel_last;

  assign item_ready = (state == S_IDLE);

  // A restore always reprograms everything; a display only when due.
  assign start_full = (stat.command == CMD_RESTORE) ||
                      ((stat.command == CMD_DISPLAY) && stat.due);

  // Short sequences write bus enable first, then one register.
  always_comb begin
    if (seq == REG_BUS_EN) begin
      sel_after = (stat.command == CMD_HIDE) ? REG_SCALE_CTL : REG_OFFSET;
    end else begin
      sel_after = seq + 4'd1;
    end
  end

  assign sel_last = full ? (seq == REG_KEY_CTL) : (seq != REG_BUS_EN);

  always_comb begin
    state_next = state;
    seq_next   = seq;
    full_next  = full;
    ctl        = '0;
    ctl.out_sel  = seq;
    ctl.out_last = sel_last;
    ctl.disp_full = start_full;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.command == CMD_SETUP) begin
          if (stat.y422) begin
            ctl.div_start = 1'b1;
            state_next    = S_DIV_H;
          end else begin
            state_next = S_ACK;
          end
        end else begin
          ctl.disp_start = (stat.command != CMD_HIDE);
          full_next      = start_full;
          seq_next       = start_full ? REG_SCALE_CTL : REG_BUS_EN;
          state_next     = S_EMIT;
        end
      end
      S_DIV_H: begin
        if (stat.div_done) begin
          ctl.store_h   = 1'b1;
          ctl.div_start = 1'b1;
          ctl.div_sel_v = 1'b1;
          state_next    = S_DIV_V;
        end
      end
      S_DIV_V: begin
        if (stat.div_done) begin
          ctl.store_v = 1'b1;
          state_next  = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = S_ACK;
      end
      S_ACK: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          ctl.out_ack  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          seq_next     = sel_after;
          if (sel_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seq   <= REG_BUS_EN;
      full  <= 1'b0;
    end else begin
      state <= state_next;
      seq   <= seq_next;
      full  <= full_next;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import orss_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASE_ITEMS = 82;
  localparam logic [31:0] ENABLE_BITS = 32'hc000_0000;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_BAD_PARAM = 1'b1;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CONFIG, STEP_PAUSE} step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    orss_item_t  item;
    logic [0:0]  index;
    logic [29:0] data;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [0:0] cfg_index;
  logic [29:0] cfg_data;

  orss_stream_if #(.T(orss_item_t)) item_ch ();
  orss_stream_if #(.T(orss_result_t)) result_ch ();

  overlay_register_setup_sequencer_core DUT (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  plan_step_t command_plan[$];
  orss_result_t pending_writes[$];
  int cycle_count = 0;
  int failures = 0;
  logic item_fired = 1'b0;

  // Sender and receiver pacing.
  int burst_left = 1;
  int gap_left = 0;
  int quiet = 0;
  int stall_left = 0;
  int stall_style = 0;

  // Predicted block state.
  logic [1:0]  screen_mode = MODE_TRUE;
  logic [29:0] scaler_base = 30'd12;
  logic [31:0] ctl_shadow = '0;
  logic [31:0] inc_shadow = '0;
  logic [15:0] pitch_shadow = '0;
  logic [31:0] size_shadow = '0;
  logic [31:0] start_shadow = '0;
  logic [31:0] end_shadow = '0;
  logic [23:0] key_color_shadow = '0;
  logic [23:0] key_mask_shadow = '0;
  logic [31:0] last_offset = '0;
  logic        full_due = 1'b1;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void push_write(input logic valid, input logic [3:0] sel,
                                     input logic [31:0] data, input logic st,
                                     input logic last);
    orss_result_t r;
    r.write_valid = valid;
    r.register_select = sel;
    r.register_data = data;
    r.status = st;
    r.last_result = last;
    pending_writes.push_back(r);
  endfunction

  // 4.12 increment of source extent over destination span, saturated.
  function automatic logic [15:0] step_ratio(input logic [10:0] extent,
                                             input logic [11:0] lo, input logic [11:0] hi);
    logic [31:0] quot;
    if (hi <= lo) return INC_SAT;
    quot = ({21'b0, extent} << 12) / {20'b0, hi - lo};
    return (quot > 32'h0000_ffff) ? INC_SAT : quot[15:0];
  endfunction

  function automatic void emit_display(input logic [31:0] offset);
    last_offset = offset;
    if (!full_due) begin
      push_write(1'b1, REG_BUS_EN, '0, ST_OK, 1'b0);
      push_write(1'b1, REG_OFFSET, offset, ST_OK, 1'b1);
    end else begin
      push_write(1'b1, REG_SCALE_CTL, ctl_shadow, ST_OK, 1'b0);
      push_write(1'b1, REG_INCREMENT, inc_shadow, ST_OK, 1'b0);
      push_write(1'b1, REG_FORMAT, FORMAT_WORD, ST_OK, 1'b0);
      push_write(1'b1, REG_PITCH, {16'b0, pitch_shadow}, ST_OK, 1'b0);
      push_write(1'b1, REG_SIZE, size_shadow, ST_OK, 1'b0);
      push_write(1'b1, REG_CAPTURE, CAPTURE_WORD, ST_OK, 1'b0);
      push_write(1'b1, REG_START, start_shadow, ST_OK, 1'b0);
      push_write(1'b1, REG_END, end_shadow, ST_OK, 1'b0);
      push_write(1'b1, REG_OFFSET, offset, ST_OK, 1'b0);
      push_write(1'b1, REG_KEY_MASK, {8'b0, key_mask_shadow}, ST_OK, 1'b0);
      push_write(1'b1, REG_KEY_COLOR, {8'b0, key_color_shadow}, ST_OK, 1'b0);
      push_write(1'b1, REG_KEY_CTL, KEY_CTL_WORD, ST_OK, 1'b1);
      full_due = 1'b0;
    end
  endfunction

  function automatic void forecast_writes(input orss_item_t it);
    logic [7:0] red, green, blue;
    red = it.key_color_rgb[23:16];
    green = it.key_color_rgb[15:8];
    blue = it.key_color_rgb[7:0];
    case (it.command)
      CMD_SETUP: begin
        if (!it.source_is_y422) begin
          push_write(1'b0, '0, '0, ST_BAD_PARAM, 1'b1);
        end else begin
          inc_shadow = {step_ratio({1'b0, it.source_width}, it.dest_left, it.dest_right),
                        step_ratio(it.source_height, it.dest_top, it.dest_bottom)};
          pitch_shadow = it.source_pitch >> 1;
          size_shadow = {6'b0, it.source_width, 5'b0, it.source_height};
          start_shadow = {4'b0, it.dest_left, 4'b0, it.dest_top};
          end_shadow = {4'b0, it.dest_right, 4'b0, it.dest_bottom};
          ctl_shadow = {2'b0, scaler_base} | ENABLE_BITS;
          case (screen_mode)
            MODE_555: begin
              key_color_shadow = {9'b0, red[7:3], green[7:3], blue[7:3]};
              key_mask_shadow = 24'h00_7fff;
            end
            MODE_565: begin
              key_color_shadow = {8'b0, red[7:3], green[7:2], blue[7:3]};
              key_mask_shadow = 24'h00_ffff;
            end
            MODE_PALETTE: begin
              key_color_shadow = it.key_color_rgb;
              key_mask_shadow = 24'h00_00ff;
            end
            default: begin
              key_color_shadow = it.key_color_rgb;
              key_mask_shadow = 24'hff_ffff;
            end
          endcase
          full_due = 1'b1;
          push_write(1'b0, '0, '0, ST_OK, 1'b1);
        end
      end
      CMD_DISPLAY: emit_display(it.buffer_offset);
      CMD_RESTORE: begin
        full_due = 1'b1;
        emit_display(last_offset);
      end
      default: begin
        push_write(1'b1, REG_BUS_EN, '0, ST_OK, 1'b0);
        push_write(1'b1, REG_SCALE_CTL, ctl_shadow & ENABLE_CLEAR, ST_OK, 1'b1);
      end
    endcase
  endfunction

  function automatic string describe(input orss_result_t r);
    return $sformatf("valid=%0b sel=%0d data=%h status=%0b last=%0b", r.write_valid,
                     r.register_select, r.register_data, r.status, r.last_result);
  endfunction

  function automatic void log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void plan_step(input step_kind_e kind, input orss_item_t it,
                                    input logic [0:0] index, input logic [29:0] data);
    plan_step_t s;
    s.kind = kind;
    s.item = it;
    s.index = index;
    s.data = data;
    command_plan.push_back(s);
  endfunction

  // Random rectangles are mostly well ordered so that real quotients show up.
  function automatic orss_item_t random_item(input logic [1:0] cmd);
    orss_item_t it;
    int span;
    it.command = cmd;
    it.source_is_y422 = 1'($urandom_range(0, 1));
    it.source_width = 10'($urandom_range(0, 1023));
    it.source_height = ($urandom_range(0, 15) == 0) ? 11'd1024 : 11'($urandom_range(0, 1023));
    it.source_pitch = 16'($urandom);
    it.key_color_rgb = 24'($urandom);
    it.buffer_offset = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      it.dest_left = 12'($urandom);
      it.dest_top = 12'($urandom);
      it.dest_right = ($urandom_range(0, 7) == 0) ? it.dest_left : 12'($urandom);
      it.dest_bottom = ($urandom_range(0, 7) == 0) ? it.dest_top : 12'($urandom);
    end else begin
      it.dest_left = 12'($urandom_range(0, 3500));
      span = $urandom_range(1, 4095 - it.dest_left);
      it.dest_right = it.dest_left + 12'(span);
      it.dest_top = 12'($urandom_range(0, 3500));
      span = $urandom_range(1, 4095 - it.dest_top);
      it.dest_bottom = it.dest_top + 12'(span);
    end
    return it;
  endfunction

  // Sender: one item at a time from the plan, with bursts and gaps.
  always @(negedge clk) begin : driver
    logic next_valid;
    orss_item_t next_item;
    logic next_write;
    logic [0:0] next_index;
    logic [29:0] next_data;
    plan_step_t head;
    next_valid = item_ch.valid;
    next_item = item_ch.payload;
    next_write = 1'b0;
    next_index = cfg_index;
    next_data = cfg_data;
    if (item_fired) next_valid = 1'b0;
    quiet = (!next_valid && pending_writes.size() == 0) ? quiet + 1 : 0;
    if (!rst && !next_valid && command_plan.size() > 0) begin
      head = command_plan[0];
      if (head.kind == STEP_ITEM) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          next_valid = 1'b1;
          next_item = head.item;
          void'(command_plan.pop_front());
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end
        end
      end else if (quiet > SETTLE_CYCLES) begin
        // Register writes and pauses both wait for the block to go idle.
        if (head.kind == STEP_CONFIG) begin
          next_write = 1'b1;
          next_index = head.index;
          next_data = head.data;
          if (head.index == CFG_SCREEN_MODE) screen_mode = head.data[1:0];
          else scaler_base = head.data;
        end
        void'(command_plan.pop_front());
        quiet = 0;
      end
    end
    item_ch.valid <= next_valid;
    item_ch.payload <= next_item;
    cfg_write <= next_write;
    cfg_index <= next_index;
    cfg_data <= next_data;
  end

  // Receiver: alternates between several stall styles.
  always @(negedge clk) begin : receiver
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= 1'($urandom_range(0, 1));
      2: result_ch.ready <= ($urandom_range(0, 3) == 0);
      default: result_ch.ready <= ((cycle_count % 16) < 4);
    endcase
  end

  always @(posedge clk) begin : monitor
    orss_result_t got;
    orss_result_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (pending_writes.size() == 0) begin
          log_failure({"unexpected transfer: ", describe(got)});
        end else begin
          want = pending_writes.pop_front();
          if (got.write_valid !== want.write_valid ||
              got.register_select !== want.register_select ||
              got.register_data !== want.register_data ||
              got.status !== want.status ||
              got.last_result !== want.last_result)
            log_failure({"expected ", describe(want), " got ", describe(got)});
        end
      end
      if (item_ch.valid && item_ch.ready) forecast_writes(item_ch.payload);
    end
    item_fired <= !rst && item_ch.valid && item_ch.ready;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    orss_item_t it;
    int made;
    int pick;
    int follow;
    logic [1:0] phase_mode [5];
    logic [29:0] phase_base [5];

    item_ch.valid = 1'b0;
    item_ch.payload = '0;
    result_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // Directed part, at the reset configuration.
    it = random_item(CMD_DISPLAY);
    it.buffer_offset = 32'hffff_ffff;
    plan_step(STEP_ITEM, it, '0, '0);
    it = random_item(CMD_DISPLAY);
    it.buffer_offset = '0;
    plan_step(STEP_ITEM, it, '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_HIDE), '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_RESTORE), '0, '0);
    // A rejected setup must leave the shadows and the reprogram flag alone.
    it = '1;
    it.command = CMD_SETUP;
    it.source_is_y422 = 1'b0;
    it.source_height = 11'd1024;
    plan_step(STEP_ITEM, it, '0, '0);
    it = random_item(CMD_DISPLAY);
    it.buffer_offset = 32'h5a5a_5a5a;
    plan_step(STEP_ITEM, it, '0, '0);
    it = '1;
    it.command = CMD_SETUP;
    it.source_height = 11'd1024;
    it.dest_left = '0;
    it.dest_top = '0;
    plan_step(STEP_ITEM, it, '0, '0);
    it = random_item(CMD_DISPLAY);
    it.buffer_offset = 32'ha5a5_a5a5;
    plan_step(STEP_ITEM, it, '0, '0);
    // Zero horizontal span and negative vertical span.
    it = '0;
    it.command = CMD_SETUP;
    it.source_is_y422 = 1'b1;
    it.source_pitch = 16'd1;
    it.dest_left = 12'd100;
    it.dest_right = 12'd100;
    it.dest_top = 12'hfff;
    plan_step(STEP_ITEM, it, '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_HIDE), '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_DISPLAY), '0, '0);
    // Spans of one pixel make both quotients saturate.
    it = random_item(CMD_SETUP);
    it.source_is_y422 = 1'b1;
    it.source_width = 10'd1023;
    it.source_height = 11'd1024;
    it.dest_left = 12'd10;
    it.dest_right = 12'd11;
    it.dest_top = 12'd7;
    it.dest_bottom = 12'd8;
    plan_step(STEP_ITEM, it, '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_RESTORE), '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_HIDE), '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_DISPLAY), '0, '0);
    it = random_item(CMD_SETUP);
    it.source_is_y422 = 1'b1;
    it.source_width = 10'd1;
    it.source_height = '0;
    it.dest_left = '0;
    it.dest_right = 12'hfff;
    it.dest_top = 12'd3;
    it.dest_bottom = 12'd8;
    plan_step(STEP_ITEM, it, '0, '0);
    plan_step(STEP_ITEM, random_item(CMD_DISPLAY), '0, '0);

    // Random phases, each under its own configuration.
    phase_mode[0] = MODE_555;
    phase_base[0] = '0;
    phase_mode[1] = MODE_565;
    phase_base[1] = '1;
    phase_mode[2] = MODE_PALETTE;
    phase_base[2] = 30'($urandom);
    phase_mode[3] = MODE_TRUE;
    phase_base[3] = 30'($urandom);
    phase_mode[4] = 2'($urandom_range(0, 3));
    phase_base[4] = 30'($urandom);
    for (int p = 0; p < 5; p++) begin
      plan_step(STEP_CONFIG, '0, CFG_SCREEN_MODE, {28'($urandom), phase_mode[p]});
      plan_step(STEP_CONFIG, '0, CFG_SCALER_BASE, phase_base[p]);
      made = 0;
      while (made < PHASE_ITEMS) begin
        if (made >= PHASE_ITEMS / 2 && made < PHASE_ITEMS / 2 + 4)
          plan_step(STEP_PAUSE, '0, '0, '0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          it = random_item(CMD_SETUP);
          it.source_is_y422 = 1'b1;
          plan_step(STEP_ITEM, it, '0, '0);
          made++;
          follow = $urandom_range(1, 4);
          repeat (follow) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) plan_step(STEP_ITEM, random_item(CMD_DISPLAY), '0, '0);
            else if (pick < 8) plan_step(STEP_ITEM, random_item(CMD_RESTORE), '0, '0);
            else plan_step(STEP_ITEM, random_item(CMD_HIDE), '0, '0);
            made++;
          end
        end else if (pick == 7) begin
          it = random_item(CMD_SETUP);
          it.source_is_y422 = 1'b0;
          plan_step(STEP_ITEM, it, '0, '0);
          plan_step(STEP_ITEM, random_item(CMD_DISPLAY), '0, '0);
          made += 2;
        end else begin
          plan_step(STEP_ITEM, random_item(2'($urandom_range(0, 3))), '0, '0);
          made++;
        end
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (command_plan.size() > 0 || item_ch.valid || pending_writes.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_writes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
